// ----- sv/modbus_single_register_responder_defines.svh -----
// Assertion macros used by msr_back, the reply side of the responder.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef MODBUS_SINGLE_REGISTER_RESPONDER_DEFINES_SVH
`define MODBUS_SINGLE_REGISTER_RESPONDER_DEFINES_SVH

// same-cycle implication
`define MSR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("msr assertion failed");

// next-cycle implication
`define MSR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("msr assertion failed");

`endif

// ----- sv/msr_pkg.sv -----
// Types, codes and the CRC-16 step for the Modbus single-register responder.
// No dependencies.
package msr_pkg;

	localparam logic [7:0]  FN_READ     = 8'h03;
	localparam logic [7:0]  FN_WRITE    = 8'h06;
	localparam logic [7:0]  REPLY_FN    = 8'h03;
	localparam logic [7:0]  REPLY_COUNT = 8'h05;
	localparam logic [7:0]  REPLY_HIGH  = 8'h00;
	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [15:0] CRC_POLY    = 16'hA001;

	// request frame slots
	localparam logic [2:0] FP_ADDR   = 3'd0;
	localparam logic [2:0] FP_FN     = 3'd1;
	localparam logic [2:0] FP_DATA   = 3'd5;
	localparam logic [2:0] FP_CHK_LO = 3'd6;
	localparam logic [2:0] FP_LAST   = 3'd7;
	localparam logic [2:0] CRC_SPAN  = 3'd6;

	// reply byte slots
	localparam logic [2:0] RP_ADDR   = 3'd0;
	localparam logic [2:0] RP_FN     = 3'd1;
	localparam logic [2:0] RP_COUNT  = 3'd2;
	localparam logic [2:0] RP_HIGH   = 3'd3;
	localparam logic [2:0] RP_VALUE  = 3'd4;
	localparam logic [2:0] RP_CRC_LO = 3'd5;
	localparam logic [2:0] RP_CRC_HI = 3'd6;

	typedef struct packed {
		logic [7:0] addr;
		logic [7:0] value;
	} cmd_t;

	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ----- sv/msr_front.sv -----
// Request side: gathers frames, runs the request CRC, judges each frame.
// Depends on msr_pkg; pushes reply commands into msr_queue.
module msr_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [7:0]    station,
	input  logic          push,
	input  logic [7:0]    rx_byte,
	input  logic          q_full,
	output logic          q_push,
	output msr_pkg::cmd_t q_cmd
);
	import msr_pkg::*;

	logic        drop_q;
	logic [2:0]  pos_q;
	logic [15:0] crc_q;
	logic [7:0]  held_q;
	logic [7:0]  addr_q;
	logic [7:0]  fn_q;
	logic [7:0]  data_q;
	logic [7:0]  chk_lo_q;

	logic       accept;
	logic       take;
	logic       frame_end;
	logic       ok;
	logic [7:0] held_next;

	assign accept    = push && !q_full;
	assign take      = accept && !drop_q;
	assign frame_end = take && (pos_q == FP_LAST);
	assign ok        = (addr_q == station) && ({rx_byte, chk_lo_q} == crc_q) &&
		((fn_q == FN_READ) || (fn_q == FN_WRITE));
	assign held_next = (fn_q == FN_WRITE) ? data_q : held_q;

	assign q_push      = frame_end && ok;
	assign q_cmd.addr  = station;
	assign q_cmd.value = held_next + 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_q <= 1'b0;
			pos_q  <= FP_ADDR;
			crc_q  <= CRC_INIT;
			held_q <= 8'd1;
		end else if (accept) begin
			if (drop_q) begin
				drop_q <= 1'b0;
			end else begin
				pos_q <= pos_q + 3'd1;
				if (pos_q < CRC_SPAN) begin
					crc_q <= crc_feed(crc_q, rx_byte);
				end
				if (frame_end) begin
					crc_q <= CRC_INIT;
					if (ok) begin
						held_q <= held_next;
					end else begin
						drop_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (pos_q == FP_ADDR) begin
				addr_q <= rx_byte;
			end
			if (pos_q == FP_FN) begin
				fn_q <= rx_byte;
			end
			if (pos_q == FP_DATA) begin
				data_q <= rx_byte;
			end
			if (pos_q == FP_CHK_LO) begin
				chk_lo_q <= rx_byte;
			end
		end
	end

endmodule

// ----- sv/msr_queue.sv -----
// Command queue between the request side and the reply side.
// Depends on msr_pkg for the command type.
module msr_queue #(
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  msr_pkg::cmd_t wr_cmd,
	output logic          full,
	input  logic          rd,
	output msr_pkg::cmd_t rd_cmd,
	output logic          empty
);
	import msr_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	logic do_wr;
	logic do_rd;

	assign full   = (count_q == CW'(DEPTH));
	assign empty  = (count_q == '0);
	assign do_wr  = wr && !full;
	assign do_rd  = rd && !empty;
	assign rd_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

// ----- sv/msr_back.sv -----
// Reply side: walks the seven reply bytes of the queue head, runs the reply CRC.
// Depends on msr_pkg and the assertion macro header.
module msr_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  msr_pkg::cmd_t q_cmd,
	output logic          q_pop,
	input  logic          pop,
	output logic          empty,
	output logic [7:0]    tx_byte,
	output logic          last_of_reply
);
	import msr_pkg::*;
	`include "modbus_single_register_responder_defines.svh"

	logic [2:0]  idx_q;
	logic [15:0] crc_q;
	logic        out_valid_q;
	logic [7:0]  tx_q;
	logic        last_q;

	logic       out_free;
	logic       emit;
	logic [7:0] cur_byte;

	assign out_free = !out_valid_q || pop;
	assign emit     = !q_empty && out_free;
	assign q_pop    = emit && (idx_q == RP_CRC_HI);

	always_comb begin
		unique case (idx_q)
			RP_ADDR:   cur_byte = q_cmd.addr;
			RP_FN:     cur_byte = REPLY_FN;
			RP_COUNT:  cur_byte = REPLY_COUNT;
			RP_HIGH:   cur_byte = REPLY_HIGH;
			RP_VALUE:  cur_byte = q_cmd.value;
			RP_CRC_LO: cur_byte = crc_q[7:0];
			RP_CRC_HI: cur_byte = crc_q[15:8];
			default:   cur_byte = REPLY_HIGH;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= RP_ADDR;
			crc_q       <= CRC_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				if (idx_q == RP_CRC_HI) begin
					idx_q <= RP_ADDR;
					crc_q <= CRC_INIT;
				end else begin
					idx_q <= idx_q + 3'd1;
					if (idx_q < RP_CRC_LO) begin
						crc_q <= crc_feed(crc_q, cur_byte);
					end
				end
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			tx_q   <= cur_byte;
			last_q <= (idx_q == RP_CRC_HI);
		end
	end

	assign empty         = !out_valid_q;
	assign tx_byte       = tx_q;
	assign last_of_reply = last_q;

	`MSR_ASSERT_NOW(a_idx_range, 1'b1, idx_q <= RP_CRC_HI)
	`MSR_ASSERT_NOW(a_pop_at_end, q_pop, idx_q == RP_CRC_HI)
	`MSR_ASSERT_NOW(a_cmd_held, idx_q != RP_ADDR, !q_empty)
	`MSR_ASSERT_NEXT(a_crc_restart, q_pop, (crc_q == CRC_INIT) && (idx_q == RP_ADDR))

endmodule

// ----- sv/modbus_single_register_responder.sv -----
// Modbus single-register responder: 8-byte requests in, 7-byte replies out.
// Takes one request byte per cycle while the queue is not full.
// A good request queues a command; tx_byte shows the first reply byte from a register.
// Throughput is set by the reply walker: one queue-head byte per cycle while pop is held.
// Asynchronous active-low reset: frame position 0, held value 1, station address 1.
module modbus_single_register_responder #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write,
	input  logic [7:0] cfg_data,
	input  logic       push,
	output logic       full,
	input  logic [7:0] rx_byte,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] tx_byte,
	output logic       last_of_reply
);
	import msr_pkg::*;

	logic [7:0] station_q;
	logic       q_push;
	cmd_t       push_cmd;
	logic       q_full;
	logic       q_pop;
	cmd_t       head_cmd;
	logic       q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_q <= 8'd1;
		end else if (cfg_write) begin
			station_q <= cfg_data;
		end
	end

	assign full = q_full;

	msr_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.station (station_q),
		.push    (push),
		.rx_byte (rx_byte),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_cmd   (push_cmd)
	);

	msr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_push),
		.wr_cmd (push_cmd),
		.full   (q_full),
		.rd     (q_pop),
		.rd_cmd (head_cmd),
		.empty  (q_empty)
	);

	msr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_cmd         (head_cmd),
		.q_pop         (q_pop),
		.pop           (pop),
		.empty         (empty),
		.tx_byte       (tx_byte),
		.last_of_reply (last_of_reply)
	);

endmodule

// ----- verif/tb_top.sv -----
// Testbench for modbus_single_register_responder: directed request frames, then random frames
// over several station addresses, with every reply byte checked against a built-in responder model.
// Depends on msr_pkg and the modbus_single_register_responder RTL.
module tb_top;
	import msr_pkg::*;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} reply_byte_t;

	typedef struct packed {
		logic [7:0]  addr;
		logic [7:0]  fn;
		logic [31:0] body;
		logic        sum_ok;
		logic        tail;
		logic [3:0]  replies;
	} frame_row_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_write;
	logic [7:0] cfg_data;
	logic       push;
	logic       full;
	logic [7:0] rx_byte;
	logic       empty;
	logic       pop;
	logic [7:0] tx_byte;
	logic       last_of_reply;

	reply_byte_t reply_q[$];
	logic [7:0]  station;
	logic [7:0]  frame_buf[8];
	logic [2:0]  slot;
	logic [7:0]  held;
	logic        skip_next;
	logic [15:0] frame_sum;
	int          made_count = 0;
	int          sent_count = 0;
	bit          calm = 1'b0;
	bit          sender_steady = 1'b0;
	bit          bad = 1'b0;

	frame_row_t plan[3] = '{
		'{8'h01, FN_READ, 32'h0000FFFF, 1'b1, 1'b0, 4'd7},
		'{8'h01, FN_WRITE, 32'hFF0000FF, 1'b1, 1'b0, 4'd7},
		'{8'hFF, 8'hFF, 32'h80808080, 1'b1, 1'b1, 4'd0}
	};

	modbus_single_register_responder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_data     (cfg_data),
		.push         (push),
		.full         (full),
		.rx_byte      (rx_byte),
		.empty        (empty),
		.pop          (pop),
		.tx_byte      (tx_byte),
		.last_of_reply(last_of_reply)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] d);
		logic fb;
		int   i;
		for (i = 0; i < 8; i++) begin
			fb = acc[0] ^ d[i];
			acc = {1'b0, acc[15:1]};
			if (fb) begin
				acc = acc ^ CRC_POLY;
			end
		end
		return acc;
	endfunction

	function automatic void absorb_rx(input logic [7:0] b);
		logic [7:0]  reply[7];
		logic [7:0]  fn;
		logic [15:0] sum;
		logic        accepted;
		int          k;
		if (skip_next) begin
			skip_next = 1'b0;
			return;
		end
		frame_buf[slot] = b;
		if (slot < 3'd6) begin
			frame_sum = crc16_step(frame_sum, b);
		end
		slot = slot + 3'd1;
		if (slot != 3'd0) begin
			return;
		end
		fn = frame_buf[FP_FN];
		accepted = frame_buf[FP_ADDR] == station &&
			{frame_buf[FP_LAST], frame_buf[FP_CHK_LO]} == frame_sum &&
			(fn == FN_READ || fn == FN_WRITE);
		frame_sum = CRC_INIT;
		if (!accepted) begin
			skip_next = 1'b1;
			return;
		end
		if (fn == FN_WRITE) begin
			held = frame_buf[FP_DATA];
		end
		reply[RP_ADDR] = station;
		reply[RP_FN] = REPLY_FN;
		reply[RP_COUNT] = REPLY_COUNT;
		reply[RP_HIGH] = REPLY_HIGH;
		reply[RP_VALUE] = held + 8'd1;
		sum = CRC_INIT;
		for (k = 0; k < 5; k++) begin
			sum = crc16_step(sum, reply[k]);
		end
		reply[RP_CRC_LO] = sum[7:0];
		reply[RP_CRC_HI] = sum[15:8];
		for (k = 0; k < 7; k++) begin
			reply_q.push_back('{reply[k], k == 6});
			made_count++;
		end
	endfunction

	task automatic put_byte(input logic [7:0] b);
		if (!calm && !sender_steady && $urandom_range(0, 4) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		push <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!(push && !full));
		absorb_rx(b);
		sent_count++;
		@(negedge clk);
	endtask

	task automatic send_frame(input logic [7:0] addr, input logic [7:0] fn,
			input logic [31:0] body, input logic sum_ok);
		logic [7:0]  bytes[8];
		logic [15:0] sum;
		int          k;
		bytes[0] = addr;
		bytes[1] = fn;
		bytes[2] = body[31:24];
		bytes[3] = body[23:16];
		bytes[4] = body[15:8];
		bytes[5] = body[7:0];
		sum = CRC_INIT;
		for (k = 0; k < 6; k++) begin
			sum = crc16_step(sum, bytes[k]);
		end
		if (!sum_ok) begin
			sum = sum ^ 16'($urandom_range(1, 65535));
		end
		bytes[6] = sum[7:0];
		bytes[7] = sum[15:8];
		for (k = 0; k < 8; k++) begin
			put_byte(bytes[k]);
		end
	endtask

	task automatic random_frame();
		logic [7:0] addr;
		logic [7:0] fn;
		int         roll;
		sender_steady = ($urandom_range(0, 2) == 0);
		while (slot != 3'd0) begin
			put_byte(8'($urandom));
		end
		if ($urandom_range(0, 19) == 0) begin
			repeat ($urandom_range(1, 3)) put_byte(8'($urandom));
		end
		addr = ($urandom_range(0, 19) < 17) ? station : 8'($urandom);
		roll = $urandom_range(0, 19);
		if (roll < 9) begin
			fn = FN_READ;
		end else if (roll < 17) begin
			fn = FN_WRITE;
		end else begin
			fn = 8'($urandom);
		end
		send_frame(addr, fn, $urandom, $urandom_range(0, 6) != 0);
		if (skip_next && $urandom_range(0, 9) != 0) begin
			put_byte(8'($urandom));
		end
	endtask

	task automatic settle();
		push <= 1'b0;
		while (reply_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (16) @(negedge clk);
	endtask

	task automatic write_station(input logic [7:0] v);
		cfg_write <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_write <= 1'b0;
		station = v;
	endtask

	initial begin
		int r;
		int phase;
		int made_before;
		push = 1'b0;
		rx_byte = 8'h00;
		cfg_write = 1'b0;
		cfg_data = 8'h00;
		arst_n = 1'b0;
		station = 8'h01;
		slot = 3'd0;
		held = 8'h01;
		skip_next = 1'b0;
		frame_sum = CRC_INIT;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (r = 0; r < 3; r++) begin
			made_before = made_count;
			send_frame(plan[r].addr, plan[r].fn, plan[r].body, plan[r].sum_ok);
			if (plan[r].tail) begin
				put_byte(8'h01);
			end
			if (made_count - made_before != int'(plan[r].replies)) begin
				$error("replies: expected %0d, actual %0d", plan[r].replies,
					made_count - made_before);
				bad = 1'b1;
			end
		end

		for (phase = 0; phase < 4; phase++) begin
			settle();
			case (phase)
				0: begin
					write_station(8'h00);
				end
				1: begin
					write_station(8'hFF);
				end
				default: begin
					write_station(8'($urandom));
				end
			endcase
			calm = (phase == 3);
			sent_count = 0;
			while (sent_count < 100) begin
				random_frame();
			end
		end
		settle();
		if (!bad) begin
			$display("modbus_single_register_responder: match");
		end else begin
			$display("modbus_single_register_responder: mismatch");
		end
		$finish;
	end

	initial begin
		int hold_left;
		int tick;
		bit steady;
		hold_left = 0;
		tick = 0;
		steady = 1'b0;
		pop = 1'b0;
		forever begin
			@(negedge clk);
			tick++;
			if (tick % 80 == 0) begin
				steady = ($urandom_range(0, 2) == 0);
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (arst_n && !calm && !steady && $urandom_range(0, 7) == 0) begin
				hold_left = $urandom_range(1, 14) - 1;
				pop <= 1'b0;
			end else begin
				pop <= arst_n;
			end
		end
	end

	always @(posedge clk) begin
		reply_byte_t want;
		if (arst_n && pop && !empty) begin
			if (reply_q.size() == 0) begin
				$error("tx_byte: expected none, actual %02h", tx_byte);
				bad = 1'b1;
			end else begin
				want = reply_q.pop_front();
				if (tx_byte !== want.data) begin
					$error("tx_byte: expected %02h, actual %02h", want.data, tx_byte);
					bad = 1'b1;
				end
				if (last_of_reply !== want.last) begin
					$error("last_of_reply: expected %0b, actual %0b", want.last,
						last_of_reply);
					bad = 1'b1;
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("modbus_single_register_responder: mismatch");
		$finish;
	end

endmodule
